### src/shtp_pkg.sv
// Shared types, constants and tables for the sprite hit projection block.
`default_nettype none

package shtp_pkg;

    localparam int MAX_SPRITES = 64;
    localparam int MAX_COLUMNS = 1024;
    localparam int SLOT_W      = $clog2(MAX_SPRITES);
    localparam int CNT_W       = $clog2(MAX_SPRITES + 1);
    localparam int COL_W       = $clog2(MAX_COLUMNS);

    localparam logic [18:0] STATURE_MAX = 19'h7FFFF;
    localparam logic [27:0] SPAN_MAX    = 28'hFFFFFFF;
    localparam logic [25:0] STEP_MAX    = 26'h3FFFFFF;
    localparam logic [19:0] HALF_PI_Q   = 20'd102944;
    localparam logic [19:0] PI_Q        = 20'd205887;
    localparam logic [19:0] TWO_PI_Q    = 20'd411775;

    localparam logic [5:0] ROOT_LAST = 6'd26;
    localparam logic [5:0] DIV_LAST  = 6'd35;
    localparam logic [5:0] ROT_LAST  = 6'd17;

    typedef enum logic [1:0] {
        CFG_RENDER_WIDTH   = 2'd0,
        CFG_RENDER_HEIGHT  = 2'd1,
        CFG_TEXTURE_WIDTH  = 2'd2,
        CFG_TEXTURE_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_STATURE = 2'd0,
        DIV_SPAN    = 2'd1,
        DIV_ROW     = 2'd2,
        DIV_COL     = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic [9:0]  ray_column;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [23:0] player_x;
        logic [23:0] player_y;
    } shtp_in_t;

    typedef struct packed {
        logic [5:0]         sprite_slot;
        logic               is_new;
        logic               table_full;
        logic [24:0]        distance;
        logic [18:0]        stature;
        logic signed [11:0] top_row;
        logic signed [11:0] bottom_row;
        logic [27:0]        proj_width;
        logic [18:0]        mid_angle;
        logic [25:0]        row_step;
        logic [25:0]        column_step;
    } shtp_out_t;

    typedef struct packed {
        logic     clr_step;
        logic     load;
        logic     rd;
        logic     next;
        logic     hit;
        logic     set_full;
        logic     store;
        logic     mark_rd;
        logic     mark_wr;
        logic     mul_x;
        logic     mul_y;
        logic     mul_sp;
        logic     root_run;
        logic     div_run;
        div_sel_t div_sel;
        logic     out_load;
    } shtp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic srch_end;
        logic full;
        logic match;
        logic is_new;
        logic op_done;
    } shtp_stat_t;

    // Arctangent of 2^-i in Q0.16
    function automatic logic [15:0] atan_entry(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/sprite_hit_table_projection.sv
// Top level of the sprite hit table and projection block.
// After reset the ray bitmap is swept clear one slot row per cycle, all 64 rows,
// during which no hit beat is taken (configuration writes are). Each hit is
// then handled alone: the table search reads and compares one stored cell at a
// time until it finds the cell or reaches the end of the table. A new sprite
// adds the projection: two multiplies, a square root that runs the 17-step
// arctangent alongside it, a restoring division, one more multiply and three
// more restoring divisions. One result beat may wait in the output register
// while the next hit is accepted.
`default_nettype none

module sprite_hit_table_projection (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire shtp_pkg::shtp_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output shtp_pkg::shtp_out_t      out_data,
    input  wire logic                cfg_we,
    input  wire shtp_pkg::cfg_idx_t  cfg_index,
    input  wire logic [10:0]         cfg_data
);
    import shtp_pkg::*;

    shtp_cmd_t  cmd;
    shtp_stat_t stat;

    // Sequencer
    shtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath
    shtp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### src/shtp_ctrl.sv
// Sequencer for table search, bitmap update and projection arithmetic.
`default_nettype none

module shtp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire shtp_pkg::shtp_stat_t stat,
    output shtp_pkg::shtp_cmd_t     cmd
);
    import shtp_pkg::*;

    typedef enum logic [16:0] {
        S_CLEAR   = 17'h00001,
        S_IDLE    = 17'h00002,
        S_READ    = 17'h00004,
        S_CMP     = 17'h00008,
        S_STORE   = 17'h00010,
        S_MARK_RD = 17'h00020,
        S_MARK_WR = 17'h00040,
        S_MUL_X   = 17'h00080,
        S_MUL_Y   = 17'h00100,
        S_ROOT    = 17'h00200,
        S_DIV_ST  = 17'h00400,
        S_MUL_SP  = 17'h00800,
        S_DIV_SP  = 17'h01000,
        S_DIV_RS  = 17'h02000,
        S_DIV_CS  = 17'h04000,
        S_FIN     = 17'h08000,
        S_SPARE   = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_STATURE;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (stat.srch_end)
                begin
                    if (stat.full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_FIN;
                    end
                    else
                        state_next = S_STORE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_MARK_RD;
                end
                else
                begin
                    cmd.next   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = S_MARK_RD;
            end
            S_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                state_next  = stat.is_new ? S_MUL_X : S_FIN;
            end
            S_MUL_X:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_run = 1'b1;
                if (stat.op_done)
                    state_next = S_DIV_ST;
            end
            S_DIV_ST:
            begin
                cmd.div_run = 1'b1;
                cmd.div_sel = DIV_STATURE;
                if (stat.op_done)
                    state_next = S_MUL_SP;
            end
            S_MUL_SP:
            begin
                cmd.mul_sp = 1'b1;
                state_next = S_DIV_SP;
            end
            S_DIV_SP:
            begin
                cmd.div_run = 1'b1;
                cmd.div_sel = DIV_SPAN;
                if (stat.op_done)
                    state_next = S_DIV_RS;
            end
            S_DIV_RS:
            begin
                cmd.div_run = 1'b1;
                cmd.div_sel = DIV_ROW;
                if (stat.op_done)
                    state_next = S_DIV_CS;
            end
            S_DIV_CS:
            begin
                cmd.div_run = 1'b1;
                cmd.div_sel = DIV_COL;
                if (stat.op_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold a result beat until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### src/shtp_dp.sv
// Datapath: sprite table, ray bitmap, shared multiplier, root, CORDIC and divider.
`default_nettype none

module shtp_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire shtp_pkg::shtp_cmd_t  cmd,
    output shtp_pkg::shtp_stat_t      stat,
    input  wire shtp_pkg::shtp_in_t   in_data,
    input  wire logic                 cfg_we,
    input  wire shtp_pkg::cfg_idx_t   cfg_index,
    input  wire logic [10:0]          cfg_data,
    output shtp_pkg::shtp_out_t       out_data
);
    import shtp_pkg::*;

    // Configuration
    logic [10:0] rw_reg, rh_reg, tw_reg, th_reg;

    // Captured beat
    logic [9:0]  col_reg;
    logic [15:0] cell_reg;
    logic [24:0] ax_reg, ay_reg;
    logic        dxn_reg, dyn_reg;

    // Table control
    logic [CNT_W-1:0]  count_reg, idx_reg;
    logic [SLOT_W-1:0] slot_reg, clr_idx_reg;
    logic              new_reg, full_reg;
    logic [15:0]       cells_mem [MAX_SPRITES];
    logic [15:0]       cell_rd_reg;

    // Ray bitmap, one row per slot
    logic [MAX_COLUMNS-1:0] mark_mem [MAX_SPRITES];
    logic [MAX_COLUMNS-1:0] mark_row_reg, mark_row_new;
    logic [COL_W-1:0]       col_idx;
    logic                   col_ok;

    // Arithmetic
    logic [5:0]         step_reg;
    logic [51:0]        sum_reg;
    logic [25:0]        root_reg, root_n;
    logic [27:0]        rem_reg, rem_s, rem_n, trial;
    logic signed [42:0] cx_reg, cy_reg, xs, ys;
    logic signed [19:0] cz_reg;
    logic [4:0]         rot_i;
    logic [24:0]        mul_a, mul_b;
    logic [49:0]        product;
    logic [29:0]        span_prod_reg;
    logic [24:0]        dist_reg;
    logic [18:0]        stature_reg;
    logic [27:0]        span_reg;
    logic [25:0]        rstep_reg, cstep_reg;
    logic [34:0]        num_reg, quo_reg, quo_n;
    logic [27:0]        den_reg, drem_reg, drem_n;
    logic [28:0]        dshift;
    logic               dge, op_done;
    logic signed [24:0] dx_w, dy_w;
    shtp_out_t          out_reg, out_next;

    // Round a Q.9 row to nearest, half away from zero, saturate to 12 bits
    function automatic logic [11:0] round_row(input logic signed [20:0] v);
        logic [20:0] mag;
        logic [20:0] r;
        logic [11:0] res;
        mag = v[20] ? 21'(-v) : 21'(v);
        r   = (mag + 21'd256) >> 9;
        if (!v[20])
            res = (r > 21'd2047) ? 12'h7FF : r[11:0];
        else
            res = (r > 21'd2048) ? 12'h800 : 12'(21'd0 - r);
        return res;
    endfunction

    // Clamp the first-quadrant angle and move it to its quadrant
    function automatic logic [18:0] quad_angle(input logic signed [19:0] z,
                                               input logic dxn, input logic dyn);
        logic [19:0] zc;
        logic [19:0] a;
        if (z[19])
            zc = 20'd0;
        else if (z > $signed(HALF_PI_Q))
            zc = HALF_PI_Q;
        else
            zc = z;
        if (!dxn && !dyn)
            a = zc;
        else if (dxn && !dyn)
            a = PI_Q - zc;
        else if (dxn)
            a = PI_Q + zc;
        else
            a = TWO_PI_Q - zc;
        if (a >= TWO_PI_Q)
            a = a - TWO_PI_Q;
        return a[18:0];
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg <= 11'd640;
            rh_reg <= 11'd480;
            tw_reg <= 11'd64;
            th_reg <= 11'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RENDER_WIDTH:   rw_reg <= cfg_data;
                CFG_RENDER_HEIGHT:  rh_reg <= cfg_data;
                CFG_TEXTURE_WIDTH:  tw_reg <= cfg_data;
                CFG_TEXTURE_HEIGHT: th_reg <= cfg_data;
                default:            rw_reg <= rw_reg;
            endcase
        end
    end

    // Offsets from player to cell centre
    assign dx_w = $signed({1'b0, in_data.cell_x, 16'h8000}) - $signed({1'b0, in_data.player_x});
    assign dy_w = $signed({1'b0, in_data.cell_y, 16'h8000}) - $signed({1'b0, in_data.player_y});

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg  <= in_data.ray_column;
            cell_reg <= {in_data.cell_y, in_data.cell_x};
            ax_reg   <= dx_w[24] ? 25'(-dx_w) : 25'(dx_w);
            ay_reg   <= dy_w[24] ? 25'(-dy_w) : 25'(dy_w);
            dxn_reg  <= dx_w[24];
            dyn_reg  <= dy_w[24];
        end
    end

    // Table control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            idx_reg     <= '0;
            slot_reg    <= '0;
            clr_idx_reg <= '0;
            new_reg     <= 1'b0;
            full_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            if (cmd.load)
            begin
                idx_reg  <= '0;
                new_reg  <= 1'b0;
                full_reg <= 1'b0;
            end
            if (cmd.next)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.hit)
                slot_reg <= idx_reg[SLOT_W-1:0];
            if (cmd.set_full)
                full_reg <= 1'b1;
            if (cmd.store)
            begin
                slot_reg  <= count_reg[SLOT_W-1:0];
                count_reg <= count_reg + 1'b1;
                new_reg   <= 1'b1;
            end
        end
    end

    // Cell store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            cells_mem[count_reg[SLOT_W-1:0]] <= cell_reg;
        if (cmd.rd)
            cell_rd_reg <= cells_mem[idx_reg[SLOT_W-1:0]];
    end

    // Bitmap: clear rows after reset, then set one column bit per hit that has a slot
    assign col_idx = COL_W'(col_reg);
    assign col_ok  = 32'(col_reg) < MAX_COLUMNS;

    always_comb
    begin
        mark_row_new          = mark_row_reg;
        mark_row_new[col_idx] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            mark_mem[clr_idx_reg] <= '0;
        else if (cmd.mark_wr && col_ok)
            mark_mem[slot_reg] <= mark_row_new;
        if (cmd.mark_rd)
            mark_row_reg <= mark_mem[slot_reg];
    end

    // Shared multiplier
    always_comb
    begin
        mul_a = ax_reg;
        mul_b = ax_reg;
        if (cmd.mul_y)
        begin
            mul_a = ay_reg;
            mul_b = ay_reg;
        end
        else if (cmd.mul_sp)
        begin
            mul_a = 25'(tw_reg);
            mul_b = 25'(stature_reg);
        end
    end
    assign product = mul_a * mul_b;

    // Square root step: two bits of the radicand per cycle
    assign rem_s  = {rem_reg[25:0], sum_reg[51:50]};
    assign trial  = {root_reg, 2'b01};
    assign rem_n  = (rem_s >= trial) ? rem_s - trial : rem_s;
    assign root_n = {root_reg[24:0], rem_s >= trial};

    // CORDIC vectoring step
    assign rot_i = 5'(step_reg - 6'd1);
    assign xs    = cx_reg >>> rot_i;
    assign ys    = cy_reg >>> rot_i;

    // Divider step: one quotient bit per cycle
    assign dshift = {drem_reg, num_reg[34]};
    assign dge    = dshift >= {1'b0, den_reg};
    assign drem_n = dge ? 28'(dshift - {1'b0, den_reg}) : dshift[27:0];
    assign quo_n  = {quo_reg[33:0], dge};

    assign op_done = (cmd.root_run && step_reg == ROOT_LAST)
                   || (cmd.div_run && step_reg == DIV_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.root_run || cmd.div_run)
            step_reg <= op_done ? 6'd0 : step_reg + 6'd1;
    end

    // Arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_x)
            sum_reg <= 52'(product);
        if (cmd.mul_y)
            sum_reg <= sum_reg + 52'(product);
        if (cmd.mul_sp)
            span_prod_reg <= product[29:0];

        if (cmd.root_run)
        begin
            if (step_reg == 6'd0)
            begin
                rem_reg  <= '0;
                root_reg <= '0;
                cx_reg   <= $signed({2'b00, ax_reg, 16'h0000});
                cy_reg   <= $signed({2'b00, ay_reg, 16'h0000});
                cz_reg   <= '0;
            end
            else
            begin
                rem_reg  <= rem_n;
                root_reg <= root_n;
                sum_reg  <= {sum_reg[49:0], 2'b00};
                if (step_reg <= ROT_LAST)
                begin
                    if (!cy_reg[42] && cy_reg != '0)
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + $signed({4'b0000, atan_entry(rot_i)});
                    end
                    else if (cy_reg[42])
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - $signed({4'b0000, atan_entry(rot_i)});
                    end
                end
                if (step_reg == ROOT_LAST)
                    dist_reg <= root_n[24:0];
            end
        end

        if (cmd.div_run)
        begin
            if (step_reg == 6'd0)
            begin
                drem_reg <= '0;
                quo_reg  <= '0;
                case (cmd.div_sel)
                    DIV_STATURE:
                    begin
                        num_reg <= {rw_reg, 24'h000000};
                        den_reg <= 28'(dist_reg);
                    end
                    DIV_SPAN:
                    begin
                        num_reg <= 35'(span_prod_reg);
                        den_reg <= 28'(th_reg);
                    end
                    DIV_ROW:
                    begin
                        num_reg <= {th_reg, 24'h000000};
                        den_reg <= 28'(stature_reg);
                    end
                    default:
                    begin
                        num_reg <= {tw_reg, 24'h000000};
                        den_reg <= span_reg;
                    end
                endcase
            end
            else
            begin
                drem_reg <= drem_n;
                quo_reg  <= quo_n;
                num_reg  <= {num_reg[33:0], 1'b0};
                if (step_reg == DIV_LAST)
                begin
                    case (cmd.div_sel)
                        DIV_STATURE:
                            stature_reg <= (den_reg == '0 || quo_n > 35'(STATURE_MAX))
                                         ? STATURE_MAX : quo_n[18:0];
                        DIV_SPAN:
                            span_reg <= (den_reg == '0 || quo_n > 35'(SPAN_MAX))
                                      ? SPAN_MAX : quo_n[27:0];
                        DIV_ROW:
                            rstep_reg <= (den_reg == '0 || quo_n > 35'(STEP_MAX))
                                       ? STEP_MAX : quo_n[25:0];
                        default:
                            cstep_reg <= (den_reg == '0 || quo_n > 35'(STEP_MAX))
                                       ? STEP_MAX : quo_n[25:0];
                    endcase
                end
            end
        end
    end

    // Assemble the result beat
    always_comb
    begin
        out_next            = '0;
        out_next.table_full = full_reg;
        out_next.is_new     = new_reg;
        if (!full_reg)
            out_next.sprite_slot = 6'(slot_reg);
        if (new_reg)
        begin
            out_next.distance    = dist_reg;
            out_next.stature     = stature_reg;
            out_next.top_row     = round_row($signed({2'b00, rh_reg, 8'h00})
                                             - $signed({2'b00, stature_reg}));
            out_next.bottom_row  = round_row($signed({2'b00, rh_reg, 8'h00})
                                             + $signed({2'b00, stature_reg}));
            out_next.proj_width  = span_reg;
            out_next.mid_angle   = (ax_reg == '0 && ay_reg == '0)
                                 ? 19'd0 : quad_angle(cz_reg, dxn_reg, dyn_reg);
            out_next.row_step    = rstep_reg;
            out_next.column_step = cstep_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= out_next;
    end

    // Status to the sequencer
    always_comb
    begin
        stat.clr_done = clr_idx_reg == SLOT_W'(MAX_SPRITES - 1);
        stat.srch_end = idx_reg >= count_reg;
        stat.full     = count_reg >= CNT_W'(MAX_SPRITES);
        stat.match    = cell_rd_reg == cell_reg;
        stat.is_new   = new_reg;
        stat.op_done  = op_done;
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

### src/shtp_chk.sv
// Port checker for the sprite hit projection block, bound to the top level.
`default_nettype none

module shtp_chk (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire shtp_pkg::shtp_in_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire shtp_pkg::shtp_out_t out_data,
    input wire logic                cfg_we,
    input wire shtp_pkg::cfg_idx_t  cfg_index,
    input wire logic [10:0]         cfg_data
);
    import shtp_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Go busy after taking a hit
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("hit taken while busy");

    // A new sprite is never a dropped one
    a_new_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.is_new && out_data.table_full))
        else $error("new and full together");

    // Drop carries no slot
    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.table_full |-> out_data.sprite_slot == 6'd0)
        else $error("dropped hit reports a slot");

    // Known sprite carries no geometry
    a_known_geom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_new |-> out_data.distance == '0
            && out_data.stature == '0 && out_data.row_step == '0)
        else $error("geometry on a known sprite");

endmodule

bind sprite_hit_table_projection shtp_chk u_shtp_chk (.*);

`default_nettype wire

### tb/shtp_checker.sv
// Scoreboard for the sprite hit block: predicts each result beat and compares it.
module shtp_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire shtp_pkg::shtp_in_t  in_data,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire shtp_pkg::shtp_out_t out_data,
    input  wire logic                cfg_we,
    input  wire shtp_pkg::cfg_idx_t  cfg_index,
    input  wire logic [10:0]         cfg_data,
    output int                       errors,
    output int                       pending
);
    import shtp_pkg::*;

    localparam longint ANGLE_STEP [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                           512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    // Own copy of the registers and the sprite table
    longint    render_w, render_h, tex_w, tex_h;
    logic [15:0] known_cells [MAX_SPRITES];
    int        sprites_stored;
    shtp_out_t expected_beats [$];

    assign pending = expected_beats.size();

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root, bit_w;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w >>= 2;
        while (bit_w != 0)
        begin
            if (v >= root + bit_w)
            begin
                v    = v - (root + bit_w);
                root = (root >> 1) + bit_w;
            end
            else
                root >>= 1;
            bit_w >>= 2;
        end
        return root;
    endfunction

    function automatic longint clamp_div(input longint num, input longint den,
                                         input longint top);
        longint q;
        if (den == 0)
            return top;
        q = num / den;
        return (q > top) ? top : q;
    endfunction

    // Round half away from zero from Q.9 to whole rows, clamp to 12 bits
    function automatic longint to_row(input longint v);
        longint r;
        if (v >= 0)
            r = (v + 256) >>> 9;
        else
            r = -((-v + 256) >>> 9);
        if (r > 2047)
            r = 2047;
        if (r < -2048)
            r = -2048;
        return r;
    endfunction

    // First-quadrant vectoring rotation, then fold into the quadrant of the offset
    function automatic longint heading(input longint dx, input longint dy);
        longint x, y, z, nx, a;
        x = ((dx < 0) ? -dx : dx) <<< 16;
        y = ((dy < 0) ? -dy : dy) <<< 16;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        for (int i = 0; i < 17; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                x  = nx;
                z += ANGLE_STEP[i];
            end
            else if (y < 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                x  = nx;
                z -= ANGLE_STEP[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(HALF_PI_Q))
            z = HALF_PI_Q;
        if (dx >= 0 && dy >= 0)
            a = z;
        else if (dx < 0 && dy >= 0)
            a = longint'(PI_Q) - z;
        else if (dx < 0)
            a = longint'(PI_Q) + z;
        else
            a = longint'(TWO_PI_Q) - z;
        if (a >= longint'(TWO_PI_Q))
            a -= longint'(TWO_PI_Q);
        return a;
    endfunction

    function automatic shtp_out_t project_hit(input shtp_in_t h);
        shtp_out_t res;
        logic [15:0] cell_key;
        longint dx, dy, hyp, stat, span;
        res      = '0;
        cell_key = {h.cell_y, h.cell_x};
        // Known cell: report slot only
        for (int c = 0; c < sprites_stored; c++)
            if (known_cells[c] == cell_key)
            begin
                res.sprite_slot = 6'(c);
                return res;
            end
        if (sprites_stored >= MAX_SPRITES)
        begin
            res.table_full = 1'b1;
            return res;
        end
        known_cells[sprites_stored] = cell_key;
        res.sprite_slot = 6'(sprites_stored);
        sprites_stored++;
        dx   = longint'({h.cell_x, 16'h8000});
        dy   = longint'({h.cell_y, 16'h8000});
        dx   = dx - longint'(h.player_x);
        dy   = dy - longint'(h.player_y);
        hyp  = int_sqrt(dx * dx + dy * dy);
        stat = clamp_div(render_w << 24, hyp, STATURE_MAX);
        span = clamp_div(tex_w * stat, tex_h, SPAN_MAX);
        res.is_new      = 1'b1;
        res.distance    = hyp[24:0];
        res.stature     = stat[18:0];
        res.top_row     = 12'(to_row(render_h * 256 - stat));
        res.bottom_row  = 12'(to_row(render_h * 256 + stat));
        res.proj_width  = span[27:0];
        res.mid_angle   = 19'(heading(dx, dy));
        res.row_step    = 26'(clamp_div(tex_h << 24, stat, STEP_MAX));
        res.column_step = 26'(clamp_div(tex_w << 24, span, STEP_MAX));
        return res;
    endfunction

    task automatic compare_beat(input shtp_out_t got, input shtp_out_t want);
        if (got.sprite_slot != want.sprite_slot)
            report("sprite_slot", got.sprite_slot, want.sprite_slot);
        if (got.is_new != want.is_new)
            report("is_new", got.is_new, want.is_new);
        if (got.table_full != want.table_full)
            report("table_full", got.table_full, want.table_full);
        if (got.distance != want.distance)
            report("distance", got.distance, want.distance);
        if (got.stature != want.stature)
            report("stature", got.stature, want.stature);
        if (got.top_row != want.top_row)
            report("top_row", got.top_row, want.top_row);
        if (got.bottom_row != want.bottom_row)
            report("bottom_row", got.bottom_row, want.bottom_row);
        if (got.proj_width != want.proj_width)
            report("proj_width", got.proj_width, want.proj_width);
        if (got.mid_angle != want.mid_angle)
            report("mid_angle", got.mid_angle, want.mid_angle);
        if (got.row_step != want.row_step)
            report("row_step", got.row_step, want.row_step);
        if (got.column_step != want.column_step)
            report("column_step", got.column_step, want.column_step);
    endtask

    initial
        errors = 0;

    // Track registers, predict on each hit beat, check each result beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            render_w       = 640;
            render_h       = 480;
            tex_w          = 64;
            tex_h          = 64;
            sprites_stored = 0;
            expected_beats.delete();
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_RENDER_WIDTH:   render_w = cfg_data;
                    CFG_RENDER_HEIGHT:  render_h = cfg_data;
                    CFG_TEXTURE_WIDTH:  tex_w    = cfg_data;
                    CFG_TEXTURE_HEIGHT: tex_h    = cfg_data;
                    default:            ;
                endcase
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                    report("unexpected result beat", out_data.sprite_slot, -1);
                else
                    compare_beat(out_data, expected_beats.pop_front());
            end
            if (in_valid && in_ready)
                expected_beats.push_back(project_hit(in_data));
        end
    end

endmodule

### tb/tb_sprite_hit_table_projection.sv
// Stimulus, clock and verdict for the sprite hit table projection block.
module tb_sprite_hit_table_projection;
    import shtp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    shtp_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    shtp_out_t   out_data;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [10:0] cfg_data;
    int          errors;
    int          pending;

    logic [15:0] seen_cells [$];
    int          burst_left;
    bit          long_hold_req;

    sprite_hit_table_projection i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    shtp_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
        clk = 1'b0;
    always
        #6 clk = ~clk;

    function automatic shtp_in_t make_hit(input int col, input int cx, input int cy,
                                          input int px, input int py);
        shtp_in_t h;
        h.ray_column = 10'(col);
        h.cell_x     = 8'(cx);
        h.cell_y     = 8'(cy);
        h.player_x   = 24'(px);
        h.player_y   = 24'(py);
        return h;
    endfunction

    // Offer one hit beat, hold it until taken, then maybe pause the burst
    task automatic send_hit(input shtp_in_t h, input bit last);
        in_valid <= 1'b1;
        in_data  <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        seen_cells.push_back({h.cell_y, h.cell_x});
        burst_left--;
        if (last || burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40))
                @(posedge clk);
            burst_left = $urandom_range(1, 60);
        end
    endtask

    // Write all four registers back to back while the block is idle
    task automatic set_config(input int rw, input int rh, input int tw, input int th);
        logic [10:0] vals [4];
        cfg_idx_t    idx;
        vals = '{11'(rw), 11'(rh), 11'(tw), 11'(th)};
        while (pending != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
        cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_idx_t'(i);
            cfg_index <= idx;
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly revisit known cells, now and then a fresh one, sometimes close by
    task automatic random_phase(input int count);
        shtp_in_t    h;
        logic [15:0] cell_key;
        for (int n = 0; n < count; n++)
        begin
            if (seen_cells.size() == 0 || $urandom_range(0, 24) == 0)
                cell_key = 16'($urandom);
            else
                cell_key = seen_cells[$urandom_range(0, seen_cells.size() - 1)];
            h = make_hit($urandom_range(0, 1023), cell_key[7:0], cell_key[15:8],
                         $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
            if ($urandom_range(0, 7) == 0)
            begin
                h.player_x = {cell_key[7:0], 16'($urandom)};
                h.player_y = {cell_key[15:8], 16'($urandom)};
            end
            send_hit(h, n == count - 1);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_RENDER_WIDTH;
        cfg_data      = '0;
        burst_left    = 5;
        long_hold_req = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero distance, far corner, repeat sighting, every quadrant and axis
        send_hit(make_hit(0, 0, 0, 24'h008000, 24'h008000), 0);
        send_hit(make_hit(1023, 255, 255, 0, 0), 0);
        send_hit(make_hit(512, 0, 0, 24'h123456, 24'h654321), 0);
        send_hit(make_hit(7, 10, 10, 24'hFFFFFF, 24'hFFFFFF), 0);
        send_hit(make_hit(8, 200, 3, 0, 24'hFFFFFF), 0);
        send_hit(make_hit(9, 3, 200, 24'hFFFFFF, 0), 0);
        send_hit(make_hit(10, 20, 30, 24'h148000, 24'h100000), 0);
        send_hit(make_hit(11, 40, 30, 24'h308000, 24'h1E8000), 0);
        send_hit(make_hit(12, 50, 60, 24'h328000, 24'h500000), 0);
        send_hit(make_hit(13, 70, 60, 24'h300000, 24'h3C8000), 0);
        send_hit(make_hit(341, 255, 255, 24'hAAAAAA, 24'h555555), 1);

        // Smallest registers: far cells give zero stature and zero divisors
        set_config(1, 1, 1, 1);
        send_hit(make_hit(682, 254, 255, 0, 0), 0);
        send_hit(make_hit(3, 255, 0, 0, 24'hFFFFFF), 0);
        send_hit(make_hit(4, 128, 128, 24'h808000, 24'h808000), 1);
        long_hold_req = 1'b1;
        random_phase(350);

        set_config(1024, 1024, 1024, 1);
        send_hit(make_hit(20, 100, 100, 24'h648100, 24'h648000), 1);
        random_phase(350);

        set_config(1024, 1, 1, 1024);
        random_phase(350);

        set_config($urandom_range(1, 1024), $urandom_range(1, 1024),
                   $urandom_range(1, 1024), $urandom_range(1, 1024));
        random_phase(350);

        set_config(640, 480, 64, 64);
        random_phase(350);

        while (pending != 0)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Result side: stall patterns that change now and then, one long hold-off
    initial
    begin
        int  mode;
        bit  long_done;
        int  cycle;
        out_ready = 1'b0;
        mode      = 0;
        long_done = 1'b0;
        cycle     = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle % 300 == 0)
                mode = $urandom_range(0, 3);
            if (long_hold_req && !long_done)
            begin
                long_done = 1'b1;
                out_ready <= 1'b0;
                repeat (3000)
                    @(posedge clk);
            end
            else
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cycle % 8 < 5);
                endcase
        end
    end

    // Watchdog
    initial
    begin
        #(12 * 3_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
